### src/odp_pkg.sv
// Shared types and constants for the ordered dither to web palette unit.
// No dependencies; used by the top level, the channel quantiser and the checker.
package odp_pkg;

	// Signed width of the quantiser numerator, sized for matrix orders up to 5
	localparam int NUM_W = 24;

	localparam int LEVEL_MAX = 5;

	localparam logic [7:0] LEVEL_STEP = 8'd51;

	localparam logic [7:0] RED_WEIGHT = 8'd36;

	localparam logic [7:0] GREEN_WEIGHT = 8'd6;

	typedef logic [2:0] level_t;

	// Load enables of the quantiser stages
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	// Base 2x2 Bayer matrix, indexed [y][x]
	localparam logic [1:0] BASE_THRESH [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};

endpackage

### src/ordered_dither_to_216_palette_unit.sv
// Top level of the ordered dither to 216-colour web palette unit.
// Depends on odp_pkg and odp_chan.
//
// Usage:
//   The source channel (src_valid/src_ready) carries one pixel per item: its
//   x and y coordinates and 8-bit red, green and blue. The destination channel
//   (dst_valid/dst_ready) returns one item per pixel: the palette index
//   36r+6g+b and the three levels scaled by 51.
//   An accepted item reaches dst_valid through the four-stage pipeline
//   (threshold lookup, numerator, level compare, palette output), each stage
//   holding one item. One item is accepted every cycle while dst_ready holds.
//   When the receiver stalls, each stage holds its item while it is full and
//   the stage after it cannot take it; empty stages still fill, so src_ready
//   drops only once all four stages are full. Nothing is lost or repeated.
//   Reset clears all stage valid bits; the pipeline comes up empty and ready.
//   The Bayer matrix has side 2^MATRIX_ORDER and tiles the plane, so only the
//   low MATRIX_ORDER bits of each coordinate are used.
module ordered_dither_to_216_palette_unit #(
	parameter int MATRIX_ORDER = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        dst_valid,
	input  logic        dst_ready,
	output logic [7:0]  palette_index,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out
);

	localparam int D_W = 2 * MATRIX_ORDER;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en4;
	odp_pkg::stage_en_t en_q;

	logic [D_W-1:0] d_c;
	logic [D_W-1:0] d_s1;
	logic [7:0]     red_s1, green_s1, blue_s1;

	odp_pkg::level_t lr, lg, lb;

	logic [7:0] idx_s4, red_s4, green_s4, blue_s4;

	// A stage loads when it is empty or its item moves on
	assign en4     = !v_s4 || dst_ready;
	assign en_q.s3 = !v_s3 || en4;
	assign en_q.s2 = !v_s2 || en_q.s3;
	assign en1     = !v_s1 || en_q.s2;

	assign src_ready = en1;

	// Threshold: one base-matrix digit per coordinate bit, lowest bit most significant
	always_comb begin
		d_c = '0;
		for (int b = 0; b < MATRIX_ORDER; b++) begin
			d_c[2*(MATRIX_ORDER-1-b) +: 2] = odp_pkg::BASE_THRESH[pixel_y[b]][pixel_x[b]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= src_valid;
			end
			if (en_q.s2) begin
				v_s2 <= v_s1;
			end
			if (en_q.s3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			d_s1     <= d_c;
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
		end
	end

	odp_chan #(.MATRIX_ORDER(MATRIX_ORDER)) u_red (
		.clk    (clk),
		.en     (en_q),
		.thresh (d_s1),
		.chan   (red_s1),
		.level  (lr)
	);

	odp_chan #(.MATRIX_ORDER(MATRIX_ORDER)) u_green (
		.clk    (clk),
		.en     (en_q),
		.thresh (d_s1),
		.chan   (green_s1),
		.level  (lg)
	);

	odp_chan #(.MATRIX_ORDER(MATRIX_ORDER)) u_blue (
		.clk    (clk),
		.en     (en_q),
		.thresh (d_s1),
		.chan   (blue_s1),
		.level  (lb)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			idx_s4   <= odp_pkg::RED_WEIGHT * {5'b0, lr}
				+ odp_pkg::GREEN_WEIGHT * {5'b0, lg} + {5'b0, lb};
			red_s4   <= odp_pkg::LEVEL_STEP * {5'b0, lr};
			green_s4 <= odp_pkg::LEVEL_STEP * {5'b0, lg};
			blue_s4  <= odp_pkg::LEVEL_STEP * {5'b0, lb};
		end
	end

	assign dst_valid     = v_s4;
	assign palette_index = idx_s4;
	assign red_out       = red_s4;
	assign green_out     = green_s4;
	assign blue_out      = blue_s4;

endmodule

### src/odp_chan.sv
// Quantiser for one colour channel: numerator stage, then level compare stage.
// Depends on odp_pkg for widths, level type and stage enables.
module odp_chan #(
	parameter int MATRIX_ORDER = 2
) (
	input  logic                      clk,
	input  odp_pkg::stage_en_t        en,
	input  logic [2*MATRIX_ORDER-1:0] thresh,
	input  logic [7:0]                chan,
	output odp_pkg::level_t           level
);

	localparam int K = 1 + (1 << (2 * MATRIX_ORDER));

	logic [odp_pkg::NUM_W-1:0] num_c;
	logic [odp_pkg::NUM_W-1:0] num_s2;
	odp_pkg::level_t           lvl_c;
	odp_pkg::level_t           level_s3;

	// 6cK + 1536(1+d) - 640K, in two's complement
	always_comb begin
		num_c = odp_pkg::NUM_W'(chan) * odp_pkg::NUM_W'(6 * K)
			+ (odp_pkg::NUM_W'(thresh) + odp_pkg::NUM_W'(1)) * odp_pkg::NUM_W'(1536)
			- odp_pkg::NUM_W'(640 * K);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			num_s2 <= num_c;
		end
	end

	// Level is the count of multiples of 256K reached, capped at LEVEL_MAX; negative gives zero
	always_comb begin
		lvl_c = '0;
		if (!num_s2[odp_pkg::NUM_W-1]) begin
			for (int l = 1; l <= odp_pkg::LEVEL_MAX; l++) begin
				if (num_s2 >= odp_pkg::NUM_W'(256 * K * l)) begin
					lvl_c = odp_pkg::level_t'(l);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			level_s3 <= lvl_c;
		end
	end

	assign level = level_s3;

endmodule

### src/odp_checker.sv
// Port-level checks for the ordered dither palette unit, bound to its top level.
// Depends on odp_pkg for the level step.
module odp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       src_ready,
	input logic       dst_valid,
	input logic       dst_ready,
	input logic [7:0] palette_index,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out
);

	// A stalled result item holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid)
		else $error("result item dropped while stalled");

	a_dst_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> $stable(palette_index) && $stable(red_out)
			&& $stable(green_out) && $stable(blue_out))
		else $error("result item changed while stalled");

	// An open receiver must never block the source
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		dst_ready |-> src_ready)
		else $error("source blocked with receiver ready");

	// Index and colours must describe the same cube entry
	a_index_match: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (palette_index == 8'(36 * (red_out / odp_pkg::LEVEL_STEP)
			+ 6 * (green_out / odp_pkg::LEVEL_STEP) + blue_out / odp_pkg::LEVEL_STEP))
			&& (red_out % odp_pkg::LEVEL_STEP == 0)
			&& (green_out % odp_pkg::LEVEL_STEP == 0)
			&& (blue_out % odp_pkg::LEVEL_STEP == 0))
		else $error("palette index and colours disagree");

endmodule

bind ordered_dither_to_216_palette_unit odp_checker u_odp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.src_ready     (src_ready),
	.dst_valid     (dst_valid),
	.dst_ready     (dst_ready),
	.palette_index (palette_index),
	.red_out       (red_out),
	.green_out     (green_out),
	.blue_out      (blue_out)
);
